FILE: src/hidm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hidm_pkg
// Shared types, constants and the multiply-add schedule of the heat index
// danger monitor.
// ----------------------------------------------------------------------------
package hidm_pkg;

  // default coefficient fraction bits
  localparam int COEF_FRAC_BITS_DEF = 24;

  // integer bits kept above the coefficient fraction in the accumulator
  localparam int XW = 30;

  // field widths
  localparam int TEMP_W  = 11;
  localparam int HUM_W   = 10;
  localparam int HI_W    = 12;
  localparam int MUL_W   = 12;

  // output range and decimal scale between the rounded sum and tenths
  localparam int HI_OUT_MIN = -1000;
  localparam int HI_OUT_MAX = 2000;
  localparam int HI_SCALE   = 1000;
  localparam int X_LO       = HI_OUT_MIN * HI_SCALE;
  localparam int X_HI       = (HI_OUT_MAX + 1) * HI_SCALE;

  // constant divide by 1000 through a reciprocal, exact for YW-bit values
  localparam int YW          = 22;
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP = 23'd4294968;

  // register reset values
  localparam logic [11:0] RST_MIN_INDEX = 12'd260;
  localparam logic [10:0] RST_MIN_TEMP  = 11'd260;
  localparam logic [9:0]  RST_MIN_HUM   = 10'd400;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_MIN_INDEX = 2'd0,
    REG_MIN_TEMP  = 2'd1,
    REG_MIN_HUM   = 2'd2
  } reg_idx_t;

  // regression coefficients, round(c * 2^32)
  localparam longint COEF_Q32 [9] = '{
    -64'sd37729976680,
    64'sd6920885003,
    64'sd10043990783,
    -64'sd627563656,
    -64'sd52862861,
    -64'sd70544098,
    64'sd9499317,
    64'sd3115827,
    -64'sd15385
  };

  // payload types
  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_tenths;
    logic [HUM_W-1:0]         humidity_tenths;
  } in_item_t;

  typedef struct packed {
    logic signed [HI_W-1:0] heat_index_tenths;
    logic                   index_updated;
    logic                   danger;
  } out_item_t;

  typedef struct packed {
    logic signed [11:0] min_index;
    logic signed [10:0] min_temp;
    logic [9:0]         min_hum;
  } cfg_t;

  // multiply-add step encoding
  typedef enum logic [1:0] {
    MUL_ZERO = 2'd0,
    MUL_H    = 2'd1,
    MUL_T    = 2'd2
  } mul_sel_t;

  typedef enum logic [3:0] {
    ADD_C1     = 4'd0,
    ADD_C2     = 4'd1,
    ADD_C3     = 4'd2,
    ADD_C4     = 4'd3,
    ADD_C5     = 4'd4,
    ADD_C6     = 4'd5,
    ADD_C7     = 4'd6,
    ADD_C8     = 4'd7,
    ADD_C9     = 4'd8,
    ADD_HOLD_A = 4'd9,
    ADD_HOLD_B = 4'd10
  } add_sel_t;

  typedef enum logic [1:0] {
    SAVE_NONE = 2'd0,
    SAVE_A    = 2'd1,
    SAVE_B    = 2'd2
  } save_sel_t;

  typedef struct packed {
    mul_sel_t  mul;
    add_sel_t  add;
    save_sel_t save;
  } step_op_t;

  typedef struct packed {
    logic     load_in;
    logic     step;
    step_op_t op;
    logic     round;
    logic     scale;
    logic     load_out;
  } dp_cmd_t;

  localparam int NUM_STEPS = 11;
  localparam int STEP_W    = 4;

  // working coefficient with frac fraction bits, round half up from Q32
  function automatic longint coef_fix(input int frac, input int k);
    int     sh;
    longint q;
    sh = 32 - frac;
    if (sh < 0) sh = 0;
    if (sh > 16) sh = 16;
    q = COEF_Q32[k];
    if (sh == 0) return q;
    return (q + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // horner schedule: A0(h) saved, A1(h) saved, A2(h), then two passes in t
  function automatic step_op_t step_op(input logic [STEP_W-1:0] idx);
    step_op_t op;
    op = '{mul: MUL_ZERO, add: ADD_C1, save: SAVE_NONE};
    unique case (idx)
      4'd0:  op = '{mul: MUL_ZERO, add: ADD_C6,     save: SAVE_NONE};
      4'd1:  op = '{mul: MUL_H,    add: ADD_C3,     save: SAVE_NONE};
      4'd2:  op = '{mul: MUL_H,    add: ADD_C1,     save: SAVE_A};
      4'd3:  op = '{mul: MUL_ZERO, add: ADD_C8,     save: SAVE_NONE};
      4'd4:  op = '{mul: MUL_H,    add: ADD_C4,     save: SAVE_NONE};
      4'd5:  op = '{mul: MUL_H,    add: ADD_C2,     save: SAVE_B};
      4'd6:  op = '{mul: MUL_ZERO, add: ADD_C9,     save: SAVE_NONE};
      4'd7:  op = '{mul: MUL_H,    add: ADD_C7,     save: SAVE_NONE};
      4'd8:  op = '{mul: MUL_H,    add: ADD_C5,     save: SAVE_NONE};
      4'd9:  op = '{mul: MUL_T,    add: ADD_HOLD_B, save: SAVE_NONE};
      4'd10: op = '{mul: MUL_T,    add: ADD_HOLD_A, save: SAVE_NONE};
      default: op = '{mul: MUL_ZERO, add: ADD_C1, save: SAVE_NONE};
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

FILE: src/hidm_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hidm_regs
// APB-style register file holding the three danger thresholds.
// ----------------------------------------------------------------------------
module hidm_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [hidm_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [hidm_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic      [hidm_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                               cfg_pready,
  output hidm_pkg::cfg_t                     cfg
);
  import hidm_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // register writes, unmapped addresses ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_index <= RST_MIN_INDEX;
      cfg_r.min_temp  <= RST_MIN_TEMP;
      cfg_r.min_hum   <= RST_MIN_HUM;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_INDEX: cfg_r.min_index <= cfg_pwdata[11:0];
        REG_MIN_TEMP:  cfg_r.min_temp  <= cfg_pwdata[10:0];
        REG_MIN_HUM:   cfg_r.min_hum   <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_MIN_INDEX: cfg_prdata = {20'd0, cfg_r.min_index};
      REG_MIN_TEMP:  cfg_prdata = {21'd0, cfg_r.min_temp};
      REG_MIN_HUM:   cfg_prdata = {22'd0, cfg_r.min_hum};
      default:       cfg_prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/hidm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hidm_ctrl
// Sequencer: accepts a transaction, walks the multiply-add schedule, then
// rounding, scaling and the output load.
// ----------------------------------------------------------------------------
module hidm_ctrl (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output hidm_pkg::dp_cmd_t cmd
);
  import hidm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_ROUND,
    S_SCALE,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // state, step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          step_nxt    = '0;
          state_nxt   = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        cmd.op   = step_op(step_r);
        if (step_r == STEP_W'(NUM_STEPS - 1)) begin
          state_nxt = S_ROUND;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // output slot free or being emptied this cycle
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/hidm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hidm_dp
// Datapath: shared multiply-add accumulator, rounding and saturation,
// reciprocal divide to tenths, threshold compare and danger flag.
// ----------------------------------------------------------------------------
module hidm_dp #(
  parameter int COEF_FRAC_BITS = hidm_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire hidm_pkg::dp_cmd_t   cmd,
  input  wire hidm_pkg::in_item_t  in_data,
  input  wire hidm_pkg::cfg_t      cfg,
  output hidm_pkg::out_item_t      out_data
);
  import hidm_pkg::*;

  // fraction bits actually used, coefficient shift kept within 0..16
  localparam int FRAC_EFF = (COEF_FRAC_BITS < 16) ? 16 :
                            (COEF_FRAC_BITS > 32) ? 32 : COEF_FRAC_BITS;
  localparam int ACC_W = FRAC_EFF + XW;

  // scaled coefficients of the tenths-domain polynomial
  localparam logic signed [ACC_W-1:0] K_C1 = ACC_W'(64'sd10000 * coef_fix(FRAC_EFF, 0));
  localparam logic signed [ACC_W-1:0] K_C2 = ACC_W'(64'sd1000 * coef_fix(FRAC_EFF, 1));
  localparam logic signed [ACC_W-1:0] K_C3 = ACC_W'(64'sd1000 * coef_fix(FRAC_EFF, 2));
  localparam logic signed [ACC_W-1:0] K_C4 = ACC_W'(64'sd100 * coef_fix(FRAC_EFF, 3));
  localparam logic signed [ACC_W-1:0] K_C5 = ACC_W'(64'sd100 * coef_fix(FRAC_EFF, 4));
  localparam logic signed [ACC_W-1:0] K_C6 = ACC_W'(64'sd100 * coef_fix(FRAC_EFF, 5));
  localparam logic signed [ACC_W-1:0] K_C7 = ACC_W'(64'sd10 * coef_fix(FRAC_EFF, 6));
  localparam logic signed [ACC_W-1:0] K_C8 = ACC_W'(64'sd10 * coef_fix(FRAC_EFF, 7));
  localparam logic signed [ACC_W-1:0] K_C9 = ACC_W'(coef_fix(FRAC_EFF, 8));

  // half of 1000 * 2^F for round half up
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd500 <<< FRAC_EFF);
  localparam logic signed [XW-1:0]    X_LO_S = XW'(X_LO);
  localparam logic signed [XW-1:0]    X_HI_S = XW'(X_HI);
  localparam logic [HI_W-1:0]         HI_BIAS = HI_W'(-HI_OUT_MIN);
  localparam logic signed [HI_W-1:0]  HI_MIN_S = HI_W'(HI_OUT_MIN);
  localparam logic signed [HI_W-1:0]  HI_MAX_S = HI_W'(HI_OUT_MAX);

  logic signed [TEMP_W-1:0]      t_r;
  logic [HUM_W-1:0]              h_r;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic signed [ACC_W-1:0]       hold_a_r, hold_b_r;
  logic signed [MUL_W-1:0]       mul_op;
  logic signed [ACC_W+MUL_W-1:0] prod;
  logic signed [ACC_W-1:0]       addend;
  logic signed [ACC_W-1:0]       biased;
  logic signed [XW-1:0]          x;
  logic signed [XW-1:0]          x_off;
  logic [YW-1:0]                 y_r;
  logic                          sat_lo_r, sat_hi_r;
  logic [YW+RECIP_W-1:0]         prod_y;
  logic [HI_W-1:0]               q;
  logic signed [HI_W-1:0]        hi_nxt, hi_r;
  logic                          now;
  logic                          flag_r;
  out_item_t                     out_r;

  // capture the item
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      t_r <= in_data.temperature_tenths;
      h_r <= in_data.humidity_tenths;
    end
  end

  // multiplier operand select
  always_comb begin
    unique case (cmd.op.mul)
      MUL_ZERO: mul_op = '0;
      MUL_H:    mul_op = $signed({{(MUL_W-HUM_W){1'b0}}, h_r});
      MUL_T:    mul_op = MUL_W'(t_r);
      default:  mul_op = '0;
    endcase
  end

  // addend select
  always_comb begin
    unique case (cmd.op.add)
      ADD_C1:     addend = K_C1;
      ADD_C2:     addend = K_C2;
      ADD_C3:     addend = K_C3;
      ADD_C4:     addend = K_C4;
      ADD_C5:     addend = K_C5;
      ADD_C6:     addend = K_C6;
      ADD_C7:     addend = K_C7;
      ADD_C8:     addend = K_C8;
      ADD_C9:     addend = K_C9;
      ADD_HOLD_A: addend = hold_a_r;
      ADD_HOLD_B: addend = hold_b_r;
      default:    addend = '0;
    endcase
  end

  // multiply-add; a zero operand skips the product so a stale acc never leaks in
  assign prod    = acc_r * mul_op;
  assign acc_nxt = (cmd.op.mul == MUL_ZERO) ? addend
                                            : $signed(prod[ACC_W-1:0]) + addend;

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      acc_r <= acc_nxt;
      if (cmd.op.save == SAVE_A) hold_a_r <= acc_nxt;
      if (cmd.op.save == SAVE_B) hold_b_r <= acc_nxt;
    end
  end

  // add half a tenth, truncate to integer thousandths of tenths, check saturation
  assign biased = acc_r + HALF;
  assign x      = biased[ACC_W-1:FRAC_EFF];
  assign x_off  = x - X_LO_S;

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      sat_lo_r <= (x < X_LO_S);
      sat_hi_r <= (x >= X_HI_S);
      y_r      <= x_off[YW-1:0];
    end
  end

  // divide by 1000 through the reciprocal, then remove the offset
  assign prod_y = y_r * RECIP;
  assign q      = prod_y[RECIP_SHIFT +: HI_W];

  always_comb begin
    priority if (sat_lo_r) hi_nxt = HI_MIN_S;
    else if (sat_hi_r)     hi_nxt = HI_MAX_S;
    else                   hi_nxt = $signed(q - HI_BIAS);
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      hi_r <= hi_nxt;
    end
  end

  // threshold compare
  assign now = ($signed(hi_r) >= $signed(cfg.min_index))
            && ($signed(t_r) >= $signed(cfg.min_temp))
            && (h_r >= cfg.min_hum);

  // danger flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else if (cmd.load_out) begin
      flag_r <= now;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.heat_index_tenths <= hi_r;
      out_r.index_updated     <= now || flag_r;
      out_r.danger            <= now;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

FILE: src/heat_index_danger_monitor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heat_index_danger_monitor_core
// Heat index from temperature and humidity in tenths, with a danger flag
// against three programmable minimums.
// ----------------------------------------------------------------------------
// One transaction is processed at a time; a new input is taken only after
// the previous result has been loaded into the output register, which
// waits while the output side stalls. The work is eleven passes of the
// nine-term regression through one shared multiply-add unit (Horner form in
// humidity, then in temperature), followed by a round/saturate step, a
// reciprocal divide-by-1000 step and the output load. The output register
// holds a finished result while the next input is already accepted. The
// thresholds are written through the APB port at byte addresses 0, 4 and 8
// and should only change while no transaction is in flight.
// ----------------------------------------------------------------------------
module heat_index_danger_monitor_core #(
  parameter int COEF_FRAC_BITS = hidm_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire hidm_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output hidm_pkg::out_item_t               out_data,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [hidm_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [hidm_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic      [hidm_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                              cfg_pready
);
  import hidm_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  // threshold registers
  hidm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // sequencer
  hidm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic and flag
  hidm_dp #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg      (cfg),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

FILE: test/heat_index_danger_monitor_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_index_danger_monitor_core_tb
// Drives temperature and humidity readings into the heat index monitor and
// checks every report against a fixed-point predictor of the regression and
// the danger flag. Thresholds are reprogrammed between phases, with both
// channels stalling at random and one long output hold-off.
// ----------------------------------------------------------------------------
module heat_index_danger_monitor_core_tb;
  import hidm_pkg::*;

  // working coefficient shift and the scale of the exact sum in tenths
  localparam int     FRAC_SH     = 32 - COEF_FRAC_BITS_DEF;
  localparam longint TENTHS_DIV  = longint'(1000) <<< COEF_FRAC_BITS_DEF;
  localparam int     SETTLE_CYC  = 20;
  localparam int     HOLD_CYC    = 400;
  localparam int     HOLD_AT     = 1300;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // regression coefficients in Q32, c1 through c9
  localparam longint RH_Q32 [9] = '{
    -64'sd37729976680, 64'sd6920885003, 64'sd10043990783,
    -64'sd627563656,   -64'sd52862861,  -64'sd70544098,
    64'sd9499317,      64'sd3115827,    -64'sd15385
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [CFG_DW-1:0]   cfg_pwdata = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  // threshold shadow and danger state of the predictor
  logic signed [11:0]  min_index_sh = RST_MIN_INDEX;
  logic signed [10:0]  min_temp_sh  = RST_MIN_TEMP;
  logic [9:0]          min_hum_sh   = RST_MIN_HUM;
  logic                danger_state = 1'b0;

  in_item_t            pending_readings [$];
  out_item_t           expected_reports [$];
  out_item_t           want;
  logic                in_fire = 1'b0;
  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  int                  reports_seen = 0;
  int                  hold_left = 0;
  logic                hold_done = 1'b0;
  int                  mismatch_count = 0;

  heat_index_danger_monitor_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // exact regression, round half up to tenths, saturate, then update danger
  function automatic out_item_t predict_report(input in_item_t rd);
    longint    c [9];
    longint    t;
    longint    h;
    longint    acc;
    longint    idx;
    logic      now;
    out_item_t r;
    for (int k = 0; k < 9; k++) c[k] = (RH_Q32[k] + (longint'(1) <<< (FRAC_SH - 1))) >>> FRAC_SH;
    t = longint'($signed(rd.temperature_tenths));
    h = longint'(rd.humidity_tenths);
    acc = 10000 * c[0] + 1000 * c[1] * t + 1000 * c[2] * h + 100 * c[3] * (t * h)
        + 100 * c[4] * (t * t) + 100 * c[5] * (h * h) + 10 * c[6] * (t * t * h)
        + 10 * c[7] * (t * h * h) + c[8] * (t * t * h * h);
    acc = acc + TENTHS_DIV / 2;
    if (acc >= 0) idx = acc / TENTHS_DIV;
    else idx = -((-acc + TENTHS_DIV - 1) / TENTHS_DIV);
    if (idx < HI_OUT_MIN) idx = HI_OUT_MIN;
    if (idx > HI_OUT_MAX) idx = HI_OUT_MAX;
    now = (idx >= longint'(min_index_sh)) && (t >= longint'(min_temp_sh))
       && (h >= longint'(min_hum_sh));
    r.heat_index_tenths = idx[HI_W-1:0];
    r.index_updated     = now | danger_state;
    r.danger            = now;
    danger_state        = now;
    return r;
  endfunction

  // mostly readings around the warning thresholds, some across the full range
  function automatic in_item_t random_reading();
    in_item_t rd;
    int       sel;
    sel = $urandom_range(99);
    if (sel < 65) begin
      rd.temperature_tenths = TEMP_W'(int'($urandom_range(500, 150)));
      rd.humidity_tenths    = HUM_W'($urandom_range(1000, 250));
    end else if (sel < 90) begin
      rd.temperature_tenths = TEMP_W'(int'($urandom_range(1200)) - 400);
      rd.humidity_tenths    = HUM_W'($urandom_range(1000));
    end else begin
      rd.temperature_tenths = TEMP_W'($urandom);
      rd.humidity_tenths    = HUM_W'($urandom);
    end
    return rd;
  endfunction

  task automatic add_reading(input int t, input int h);
    in_item_t rd;
    rd.temperature_tenths = TEMP_W'(t);
    rd.humidity_tenths    = HUM_W'(h);
    pending_readings.push_back(rd);
  endtask

  // apb write: setup cycle, then access until pready
  task automatic write_threshold(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_MIN_INDEX: min_index_sh = value[11:0];
      REG_MIN_TEMP:  min_temp_sh  = value[10:0];
      REG_MIN_HUM:   min_hum_sh   = value[9:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_readings.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) pending_readings.push_back(random_reading());
    wait_drained();
  endtask

  task automatic random_thresholds();
    write_threshold(REG_MIN_INDEX, 32'(int'($urandom_range(500, 150))));
    write_threshold(REG_MIN_TEMP, 32'(int'($urandom_range(400, 150))));
    write_threshold(REG_MIN_HUM, 32'($urandom_range(800, 200)));
  endtask

  // input driver: next reading offered at the falling edge after a transaction
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_readings.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_data  <= pending_readings.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output ready: random stalls plus one long hold-off to back up the block
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && reports_seen == HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYC;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor: predict on input transactions, check on output transactions
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) expected_reports.push_back(predict_report(in_data));
    if (rst_n && out_valid && out_ready) begin
      reports_seen <= reports_seen + 1;
      if (expected_reports.size() == 0) begin
        $error("unexpected transaction: %p", out_data);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        if (out_data.heat_index_tenths !== want.heat_index_tenths) begin
          $error("heat_index_tenths: expected %0d, actual %0d",
                 want.heat_index_tenths, out_data.heat_index_tenths);
          mismatch_count++;
        end
        if (out_data.index_updated !== want.index_updated) begin
          $error("index_updated: expected %0b, actual %0b",
                 want.index_updated, out_data.index_updated);
          mismatch_count++;
        end
        if (out_data.danger !== want.danger) begin
          $error("danger: expected %0b, actual %0b", want.danger, out_data.danger);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus phases
  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, threshold edges, set and clear of danger
    tx_idle_pct = 19;
    rx_idle_pct = 76;
    add_reading(-400, 0);
    add_reading(800, 1000);
    add_reading(-1024, 1023);
    add_reading(1023, 1023);
    add_reading(1023, 0);
    add_reading(-1024, 0);
    add_reading(0, 0);
    add_reading(-1, 1023);
    add_reading(260, 400);
    add_reading(259, 400);
    add_reading(260, 399);
    add_reading(350, 700);
    add_reading(350, 700);
    add_reading(200, 700);
    add_reading(200, 700);
    add_reading(800, 1000);
    add_reading(500, 512);
    add_reading(300, 600);
    add_reading(260, 1000);
    add_reading(-400, 1000);
    wait_drained();

    random_thresholds();
    run_random(500);

    // lowest in-range thresholds, danger nearly always raised
    tx_idle_pct = 76;
    rx_idle_pct = 19;
    write_threshold(REG_MIN_INDEX, 32'(-1000));
    write_threshold(REG_MIN_TEMP, 32'(-400));
    write_threshold(REG_MIN_HUM, 32'd0);
    run_random(450);

    // thresholds outside the stated range, plus a write to an unused address
    write_threshold(REG_MIN_INDEX, 32'h0000_0800);
    write_threshold(REG_MIN_TEMP, 32'h0000_0400);
    write_threshold(REG_MIN_HUM, 32'd1001);
    write_threshold(REG_UNUSED, 32'hFFFF_FFFF);
    run_random(300);

    // highest in-range thresholds, no idling, sender pauses halfway
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_threshold(REG_MIN_INDEX, 32'd2000);
    write_threshold(REG_MIN_TEMP, 32'd800);
    write_threshold(REG_MIN_HUM, 32'd1000);
    run_random(100);
    run_random(100);

    random_thresholds();
    run_random(480);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
src/hidm_pkg.sv
src/hidm_regs.sv
src/hidm_ctrl.sv
src/hidm_dp.sv
src/heat_index_danger_monitor_core.sv
test/heat_index_danger_monitor_core_tb.sv
